/* rtl/vec3_arith_normalize_unit_top_macros.svh */
// Assertion macros for the vector ALU top level.
// No dependencies; include once per file that asserts.
`ifndef VEC3_ARITH_NORMALIZE_UNIT_TOP_MACROS_SVH
`define VEC3_ARITH_NORMALIZE_UNIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a property under reset gating.
`define VNA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("vna assertion failed");
// Check a property at every edge, reset included.
`define VNA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("vna assertion failed");
`else
`define VNA_ASSERT(label, prop)
`define VNA_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* rtl/vna_pkg.sv */
// Shared types and pipeline constants for the vector ALU.
// No dependencies.
package vna_pkg;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_SCL  = 4'd3,
        CMD_DIV  = 4'd4,
        CMD_SDIV = 4'd5,
        CMD_NORM = 4'd6,
        CMD_EQ   = 4'd7,
        CMD_NE   = 4'd8
    } t_cmd;

    // square root: 32 result bits, four per stage
    localparam int SQ_PER_STG  = 4;
    localparam int SQ_STG      = 32 / SQ_PER_STG;
    // divider: 33 quotient bits, three per stage, plus prep and output registers
    localparam int DIV_BITS    = 33;
    localparam int DIV_PER_STG = 3;
    localparam int DIV_STG     = DIV_BITS / DIV_PER_STG;
    localparam int DIV_LAT     = DIV_STG + 2;

endpackage

/* rtl/vec3_arith_normalize_unit_top.sv */
// Top level of the three-component vector ALU; uses vna_pkg, vna_sqrt, vna_div
// and the assertion macros header.
//
// Vector ALU on signed fixed point (FRAC_BITS fraction bits in 32-bit words).
// One transaction on the input stream carries a command, vectors a and b and a
// scalar; exactly one result transaction follows, in order, holding the result
// vector, the compare flag and a fault flag. Supported: add, subtract,
// elementwise multiply, scale, elementwise divide, divide by the scalar,
// normalize a, equal and not equal. Products round toward minus infinity,
// quotients toward zero; anything out of range saturates and sets fault, as
// does a division by zero. Normalizing the zero vector gives zero, no fault.
// Throughput is one transaction per clock while the pipe is not held. Every
// command takes the same path through 3 + SQ_STG + DIV_LAT + 1 = 25 register
// stages: an input register, the multiplier stage, the sum-of-squares stage,
// eight square-root stages (four root bits each), the thirteen-stage divider (a
// prep register, eleven stages of three quotient bits and a saturation register)
// and the output register. The whole pipe holds when a result waits and the
// sink is not ready, so back-pressure stops acceptance in the same cycle.
`include "vec3_arith_normalize_unit_top_macros.svh"
module vec3_arith_normalize_unit_top
    import vna_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[3:0], ax, ay, az, bx, by, bz, scalar (32 bits each), zero pad
    input  logic [231:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rx, ry, rz (32 bits each), compare_true, fault, zero pad
    output logic [103:0] m_axis_tdata
);

    localparam int NSTG = 3 + SQ_STG + DIV_LAT + 1;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [2:0][31:0] a;
        logic [2:0][31:0] d;
        logic [2:0][31:0] r;
        logic             flt;
        logic             cmp;
        logic             szero;
    } t_meta1;

    typedef struct packed {
        logic [3:0]       cmd;
        logic [2:0][31:0] r;
        logic             flt;
        logic             cmp;
        logic             szero;
    } t_meta2;

    typedef struct packed {
        logic [31:0] v;
        logic        f;
    } t_sat;

    function automatic t_sat sat64(input logic signed [63:0] v);
        t_sat s;
        s.f = 1'b1;
        if (v > 64'sd2147483647) begin
            s.v = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            s.v = 32'h8000_0000;
        end else begin
            s.v = v[31:0];
            s.f = 1'b0;
        end
        return s;
    endfunction

    logic            w_en;
    logic            w_accept;
    logic [NSTG-1:0] r_vld;

    // input register
    logic [3:0]              r1_cmd;
    logic signed [2:0][31:0] r1_a;
    logic signed [2:0][31:0] r1_b;
    logic signed [31:0]      r1_sc;

    // multiplier stage
    logic [3:0]              r2_cmd;
    logic [2:0][31:0]        r2_a;
    logic [2:0][31:0]        r2_d;
    logic signed [63:0]      r2_prod [3];
    logic signed [32:0]      r2_as   [3];
    logic                    r2_eq;
    logic signed [63:0]      n2_prod [3];
    logic signed [32:0]      n2_as   [3];

    // sum stage
    t_meta1      r3_meta;
    t_meta1      n3_meta;
    logic [63:0] r3_sum;

    t_meta1           r_m1 [SQ_STG];
    t_meta2           r_m2 [DIV_LAT];
    t_meta2           w_m2_in;
    logic [31:0]      w_len;
    logic signed [31:0] w_quo [3];
    logic             w_dflt [3];
    logic [31:0]      w_den [3];
    logic             w_den_neg [3];

    logic [2:0][31:0] r_res;
    logic             r_cmp;
    logic             r_flt;
    logic [2:0][31:0] n_res;
    logic             n_cmp;
    logic             n_flt;

    // hold every stage while the result waits
    assign w_en          = !r_vld[NSTG-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd  <= s_axis_tdata[3:0];
            r1_a[0] <= s_axis_tdata[35:4];
            r1_a[1] <= s_axis_tdata[67:36];
            r1_a[2] <= s_axis_tdata[99:68];
            r1_b[0] <= s_axis_tdata[131:100];
            r1_b[1] <= s_axis_tdata[163:132];
            r1_b[2] <= s_axis_tdata[195:164];
            r1_sc   <= s_axis_tdata[227:196];
        end
    end

    // one multiplier per lane, operands chosen by command
    always_comb begin
        logic signed [31:0] v_op;
        for (int i = 0; i < 3; i++) begin
            case (r1_cmd)
                CMD_MUL: v_op = r1_b[i];
                CMD_SCL: v_op = r1_sc;
                default: v_op = r1_a[i];
            endcase
            n2_prod[i] = $signed(r1_a[i]) * v_op;
            if (r1_cmd == CMD_SUB) begin
                n2_as[i] = 33'($signed(r1_a[i])) - 33'($signed(r1_b[i]));
            end else begin
                n2_as[i] = 33'($signed(r1_a[i])) + 33'($signed(r1_b[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_cmd <= r1_cmd;
            r2_eq  <= (r1_a == r1_b);
            for (int i = 0; i < 3; i++) begin
                r2_a[i]    <= r1_a[i];
                r2_d[i]    <= (r1_cmd == CMD_SDIV) ? r1_sc : r1_b[i];
                r2_prod[i] <= n2_prod[i];
                r2_as[i]   <= n2_as[i];
            end
        end
    end

    // saturate the non-dividing commands; add up the squares for normalize
    always_comb begin
        t_sat v_s;
        n3_meta     = '0;
        n3_meta.cmd = r2_cmd;
        n3_meta.a   = r2_a;
        n3_meta.d   = r2_d;
        n3_meta.szero = (r2_prod[0] == '0) && (r2_prod[1] == '0) && (r2_prod[2] == '0);
        for (int i = 0; i < 3; i++) begin
            case (r2_cmd)
                CMD_ADD, CMD_SUB: begin
                    v_s = sat64(64'(r2_as[i]));
                end
                CMD_MUL, CMD_SCL: begin
                    v_s = sat64(r2_prod[i] >>> FRAC_BITS);
                end
                default: begin
                    v_s = '0;
                end
            endcase
            n3_meta.r[i] = v_s.v;
            n3_meta.flt  = n3_meta.flt | v_s.f;
        end
        case (r2_cmd)
            CMD_EQ:  n3_meta.cmp = r2_eq;
            CMD_NE:  n3_meta.cmp = !r2_eq;
            default: n3_meta.cmp = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_meta <= n3_meta;
            r3_sum  <= 64'(r2_prod[0]) + 64'(r2_prod[1]) + 64'(r2_prod[2]);
        end
    end

    vna_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r3_sum),
        .o_root (w_len)
    );

    // carry the item alongside the root pipeline
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1[0] <= r3_meta;
            for (int s = 1; s < SQ_STG; s++) begin
                r_m1[s] <= r_m1[s-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        always_comb begin
            if (r_m1[SQ_STG-1].cmd == CMD_NORM) begin
                w_den[i]     = w_len;
                w_den_neg[i] = 1'b0;
            end else begin
                w_den[i]     = r_m1[SQ_STG-1].d[i][31] ? 32'(-r_m1[SQ_STG-1].d[i])
                                                       : r_m1[SQ_STG-1].d[i];
                w_den_neg[i] = r_m1[SQ_STG-1].d[i][31];
            end
        end

        vna_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk     (i_clk),
            .i_en      (w_en),
            .i_num     (r_m1[SQ_STG-1].a[i]),
            .i_den     (w_den[i]),
            .i_den_neg (w_den_neg[i]),
            .o_quo     (w_quo[i]),
            .o_fault   (w_dflt[i])
        );
    end

    assign w_m2_in.cmd   = r_m1[SQ_STG-1].cmd;
    assign w_m2_in.r     = r_m1[SQ_STG-1].r;
    assign w_m2_in.flt   = r_m1[SQ_STG-1].flt;
    assign w_m2_in.cmp   = r_m1[SQ_STG-1].cmp;
    assign w_m2_in.szero = r_m1[SQ_STG-1].szero;

    // carry the item alongside the divider
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2[0] <= w_m2_in;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_m2[s] <= r_m2[s-1];
            end
        end
    end

    // pick the divider result for divides and for normalize of a non-zero vector
    always_comb begin
        t_meta2 v_m;
        logic   v_div;
        v_m   = r_m2[DIV_LAT-1];
        v_div = (v_m.cmd == CMD_DIV) || (v_m.cmd == CMD_SDIV) ||
                ((v_m.cmd == CMD_NORM) && !v_m.szero);
        n_cmp = v_m.cmp;
        if (v_div) begin
            for (int i = 0; i < 3; i++) begin
                n_res[i] = w_quo[i];
            end
            n_flt = w_dflt[0] | w_dflt[1] | w_dflt[2];
        end else begin
            n_res = v_m.r;
            n_flt = v_m.flt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
            r_cmp <= n_cmp;
            r_flt <= n_flt;
        end
    end

    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {6'd0, r_flt, r_cmp, r_res[2], r_res[1], r_res[0]};

    // a true compare always comes with a zero vector and no fault
    `VNA_ASSERT(a_cmp_clean, m_axis_tvalid && r_cmp |-> (r_res == '0) && !r_flt)
    // a held pipe does not move its valid bits
    `VNA_ASSERT(a_hold_vld, !w_en |=> $stable(r_vld))
    // nothing comes out straight after reset
    `VNA_ASSERT_ALWAYS(a_rst_quiet, !$past(i_rst_n) |-> !m_axis_tvalid)

endmodule

/* rtl/vna_sqrt.sv */
// Pipelined integer square root, floor(sqrt) of a 64-bit radicand.
// Depends on vna_pkg.
module vna_sqrt
    import vna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [33:0] r_rem  [SQ_STG];
    logic [31:0] r_root [SQ_STG];
    logic [63:0] r_rad  [SQ_STG];
    logic [33:0] w_rem  [SQ_STG+1];
    logic [31:0] w_root [SQ_STG+1];
    logic [63:0] w_rad  [SQ_STG+1];
    logic [33:0] n_rem  [SQ_STG];
    logic [31:0] n_root [SQ_STG];
    logic [63:0] n_rad  [SQ_STG];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rad[0]  = i_rad;

    for (genvar g = 0; g < SQ_STG; g++) begin : g_stg
        assign w_rem[g+1]  = r_rem[g];
        assign w_root[g+1] = r_root[g];
        assign w_rad[g+1]  = r_rad[g];

        always_comb begin
            logic [33:0] v_rem;
            logic [31:0] v_root;
            logic [63:0] v_rad;
            logic [33:0] v_trial;
            v_rem  = w_rem[g];
            v_root = w_root[g];
            v_rad  = w_rad[g];
            for (int k = 0; k < SQ_PER_STG; k++) begin
                v_rem   = {v_rem[31:0], v_rad[63:62]};
                v_rad   = {v_rad[61:0], 2'b00};
                v_trial = {v_root, 2'b01};
                if (v_rem >= v_trial) begin
                    v_rem  = v_rem - v_trial;
                    v_root = {v_root[30:0], 1'b1};
                end else begin
                    v_root = {v_root[30:0], 1'b0};
                end
            end
            n_rem[g]  = v_rem;
            n_root[g] = v_root;
            n_rad[g]  = v_rad;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem[g];
                r_root[g] <= n_root[g];
                r_rad[g]  <= n_rad[g];
            end
        end
    end

    assign o_root = r_root[SQ_STG-1];

endmodule

/* rtl/vna_div.sv */
// One lane of the pipelined fixed-point divider with saturation.
// Depends on vna_pkg.
module vna_div
    import vna_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_num,
    input  logic        [31:0] i_den,
    input  logic               i_den_neg,
    output logic signed [31:0] o_quo,
    output logic               o_fault
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = 32 + DIV_BITS;

    typedef struct packed {
        logic [DIV_BITS-1:0] rem;
        logic [DIV_BITS-1:0] quo;
        logic [DIV_BITS-1:0] low;
        logic [31:0]         den;
        logic                neg;
        logic                dz;
        logic                nz;
        logic                ovf;
    } t_dstg;

    t_dstg r_stg [DIV_STG+1];
    t_dstg n_stg [DIV_STG+1];
    logic signed [31:0] r_quo;
    logic               r_fault;
    logic signed [31:0] n_quo;
    logic               n_fault;

    // prep: magnitudes, zero and overflow checks
    always_comb begin
        logic [31:0]   v_mag;
        logic [NW-1:0] v_num;
        v_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
        v_num = {v_mag, {FRAC_BITS{1'b0}}};
        n_stg[0].rem = DIV_BITS'(v_num >> DIV_BITS);
        n_stg[0].quo = '0;
        n_stg[0].low = v_num[DIV_BITS-1:0];
        n_stg[0].den = i_den;
        n_stg[0].neg = i_num[31] ^ i_den_neg;
        n_stg[0].dz  = (i_den == '0);
        n_stg[0].nz  = (i_num != '0);
        n_stg[0].ovf = ({{(CW-NW){1'b0}}, v_num} >= {i_den, {DIV_BITS{1'b0}}});
    end

    for (genvar g = 1; g <= DIV_STG; g++) begin : g_stg
        always_comb begin
            t_dstg v_s;
            v_s = r_stg[g-1];
            for (int k = 0; k < DIV_PER_STG; k++) begin
                v_s.rem = {v_s.rem[DIV_BITS-2:0], v_s.low[DIV_BITS-1]};
                v_s.low = {v_s.low[DIV_BITS-2:0], 1'b0};
                if (v_s.rem >= {1'b0, v_s.den}) begin
                    v_s.rem = v_s.rem - {1'b0, v_s.den};
                    v_s.quo = {v_s.quo[DIV_BITS-2:0], 1'b1};
                end else begin
                    v_s.quo = {v_s.quo[DIV_BITS-2:0], 1'b0};
                end
            end
            n_stg[g] = v_s;
        end
    end

    // sign and saturate
    always_comb begin
        t_dstg v_s;
        v_s     = r_stg[DIV_STG];
        n_fault = 1'b0;
        if (v_s.dz) begin
            n_fault = 1'b1;
            n_quo   = !v_s.nz ? 32'sd0 : (v_s.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        end else if (v_s.neg) begin
            if (v_s.ovf || v_s.quo > 33'h0_8000_0000) begin
                n_fault = 1'b1;
                n_quo   = 32'sh8000_0000;
            end else begin
                n_quo   = 32'(-v_s.quo);
            end
        end else begin
            if (v_s.ovf || v_s.quo > 33'h0_7FFF_FFFF) begin
                n_fault = 1'b1;
                n_quo   = 32'sh7FFF_FFFF;
            end else begin
                n_quo   = 32'(v_s.quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s <= DIV_STG; s++) begin
                r_stg[s] <= n_stg[s];
            end
            r_quo   <= n_quo;
            r_fault <= n_fault;
        end
    end

    assign o_quo   = r_quo;
    assign o_fault = r_fault;

endmodule
